/* hw/rtl/ovd_pkg.sv */
// ----------------------------------------------------------------------------
// Ocean vertex displacement package
// Shared constants, register codes, stage records and arithmetic helpers.
// ----------------------------------------------------------------------------
package ovd_pkg;

	localparam int GRID_X_LOG2 = 8;
	localparam int GRID_Y_LOG2 = 8;

	// Width of the rest position product: 25-bit extent times signed offset.
	localparam int RX_W = 26 + GRID_X_LOG2;
	localparam int RY_W = 26 + GRID_Y_LOG2;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHOP   = 2'd0,
		REG_GAIN   = 2'd1,
		REG_EXT_X  = 2'd2,
		REG_EXT_Y  = 2'd3
	} reg_idx_t;

	localparam int MAG_W = 30;
	localparam int RAD_W = 64;
	localparam int SQ_PER_ST = 2;
	localparam int SQ_STAGES = RAD_W / (2 * SQ_PER_ST);
	localparam int QUO_W = 16;
	localparam int DV_PER_ST = 2;
	localparam int DV_STAGES = QUO_W / DV_PER_ST;
	localparam int FRONT_STAGES = 8;
	localparam int NUM_STAGES = FRONT_STAGES + SQ_STAGES + DV_STAGES + 1;

	localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] POS_MIN = -24'sh800000;
	localparam logic [QUO_W-1:0] UNIT_Q14 = 16'd16384;

	typedef struct packed {
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
		logic [15:0]        tex_u;
		logic [15:0]        tex_v;
		logic signed [23:0] slope_x;
		logic signed [23:0] slope_y;
		logic [2:0]         sgn;
		logic               zero;
	} pass_t;

	typedef struct packed {
		logic [34:0] rem;
		logic [31:0] root;
	} sq_t;

	typedef struct packed {
		logic [30:0]      rem;
		logic [QUO_W-1:0] quo;
	} dv_t;

	// Q4.12 by Q4.12 product back to Q8.12, rounding half up.
	function automatic logic signed [19:0] rnd12(input logic signed [31:0] p);
		logic signed [32:0] t;
		t = 33'(p) + 33'sd2048;
		return t[31:12];
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
		if (v > 40'(POS_MAX))
			return POS_MAX;
		else if (v < 40'(POS_MIN))
			return POS_MIN;
		else
			return v[23:0];
	endfunction

	// One digit of the integer square root, two radicand bits at a time.
	function automatic sq_t sqrt_step(input sq_t cur, input logic [1:0] bits);
		logic [34:0] r;
		logic [34:0] trial;
		sq_t nxt;
		r = {cur.rem[32:0], bits};
		trial = {1'b0, cur.root, 2'b01};
		if (r >= trial) begin
			nxt.rem = r - trial;
			nxt.root = {cur.root[30:0], 1'b1};
		end else begin
			nxt.rem = r;
			nxt.root = {cur.root[30:0], 1'b0};
		end
		return nxt;
	endfunction

	// One quotient bit of a restoring division.
	function automatic dv_t div_step(input dv_t cur, input logic b, input logic [30:0] len);
		logic [31:0] r;
		dv_t nxt;
		r = {cur.rem, b};
		if (r >= {1'b0, len}) begin
			nxt.rem = 31'(r - {1'b0, len});
			nxt.quo = {cur.quo[QUO_W-2:0], 1'b1};
		end else begin
			nxt.rem = r[30:0];
			nxt.quo = {cur.quo[QUO_W-2:0], 1'b0};
		end
		return nxt;
	endfunction

endpackage

/* hw/rtl/ovd_item_if.sv */
// ----------------------------------------------------------------------------
// Grid point channel
// One ocean grid point with the solver outputs for that point.
// ----------------------------------------------------------------------------
interface ovd_item_if;
	logic               valid;
	logic               ready;
	logic [7:0]         grid_col;
	logic [7:0]         grid_row;
	logic signed [15:0] shift_x;
	logic signed [15:0] shift_y;
	logic signed [15:0] raw_height;
	logic signed [15:0] raw_slope_x;
	logic signed [15:0] raw_slope_y;
	logic signed [15:0] dsx_by_x;
	logic signed [15:0] dsx_by_y;
	logic signed [15:0] dsy_by_x;
	logic signed [15:0] dsy_by_y;

	modport source (output valid, grid_col, grid_row, shift_x, shift_y, raw_height,
		raw_slope_x, raw_slope_y, dsx_by_x, dsx_by_y, dsy_by_x, dsy_by_y, input ready);
	modport sink (input valid, grid_col, grid_row, shift_x, shift_y, raw_height,
		raw_slope_x, raw_slope_y, dsx_by_x, dsx_by_y, dsy_by_x, dsy_by_y, output ready);
endinterface

/* hw/rtl/ovd_result_if.sv */
// ----------------------------------------------------------------------------
// Vertex result channel
// Displaced position, unit normal, texture coordinates and scaled slopes.
// ----------------------------------------------------------------------------
interface ovd_result_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_y;
	logic signed [23:0] pos_z;
	logic signed [15:0] norm_x;
	logic signed [15:0] norm_y;
	logic signed [15:0] norm_z;
	logic [15:0]        tex_u;
	logic [15:0]        tex_v;
	logic signed [23:0] out_slope_x;
	logic signed [23:0] out_slope_y;

	modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u,
		tex_v, out_slope_x, out_slope_y, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u,
		tex_v, out_slope_x, out_slope_y, output ready);
endinterface

/* hw/rtl/ovd_cfg_if.sv */
// ----------------------------------------------------------------------------
// Configuration write channel
// Register index and write data for the scale and extent registers.
// ----------------------------------------------------------------------------
interface ovd_cfg_if import ovd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/ocean_vertex_displace_normal.sv */
// ----------------------------------------------------------------------------
// Ocean vertex displacement and normal unit
// Places each grid vertex, displaces it, and forms its unit surface normal.
// ----------------------------------------------------------------------------
//  channel  | kind          | moves
//  item     | valid/ready   | one grid point with solver values
//  result   | valid/ready   | position, normal, texture coords, slopes
//  cfg      | valid/ready   | register index and write data, always ready
//
// One transaction per clock is sustained while results are taken; the front
// stages feed the 16-stage square root pipeline and the 8-stage divider behind it.
// All stages advance together; when the last stage holds an untaken result
// the whole pipeline holds and item.ready is low.
// Reset clears the stage valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module ocean_vertex_displace_normal import ovd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	ovd_item_if.sink  item,
	ovd_result_if.source result,
	ovd_cfg_if.sink   cfg
);

	localparam logic [GRID_X_LOG2:0] HALF_X = (GRID_X_LOG2 + 1)'(1) << (GRID_X_LOG2 - 1);
	localparam logic [GRID_Y_LOG2:0] HALF_Y = (GRID_Y_LOG2 + 1)'(1) << (GRID_Y_LOG2 - 1);

	logic signed [15:0] chop_q;
	logic signed [15:0] gain_q;
	logic [23:0]        ext_x_q;
	logic [23:0]        ext_y_q;

	logic [NUM_STAGES-1:0] vld_q;
	logic adv;

	assign adv = ~vld_q[NUM_STAGES-1] | result.ready;
	assign item.ready = adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chop_q <= 16'sd4096;
			gain_q <= 16'sd4096;
			ext_x_q <= 24'd1048576;
			ext_y_q <= 24'd1048576;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_CHOP:  chop_q <= $signed(cfg.data[15:0]);
				REG_GAIN:  gain_q <= $signed(cfg.data[15:0]);
				REG_EXT_X: ext_x_q <= cfg.data;
				REG_EXT_Y: ext_y_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[NUM_STAGES-2:0], item.valid};
	end

	// Stage 1: all scale products and rest position products.
	logic [GRID_X_LOG2-1:0]    colm;
	logic [GRID_Y_LOG2-1:0]    rowm;
	logic signed [GRID_X_LOG2:0] offs_x;
	logic signed [GRID_Y_LOG2:0] offs_y;

	assign colm = GRID_X_LOG2'(item.grid_col);
	assign rowm = GRID_Y_LOG2'(item.grid_row);
	assign offs_x = $signed({1'b0, colm}) - $signed(HALF_X);
	assign offs_y = $signed({1'b0, rowm}) - $signed(HALF_Y);

	logic signed [31:0] m_sx_s1, m_sy_s1, m_hz_s1, m_slx_s1, m_sly_s1;
	logic signed [31:0] m_xx_s1, m_xy_s1, m_yx_s1, m_yy_s1;
	logic signed [RX_W-1:0] r_x_s1;
	logic signed [RY_W-1:0] r_y_s1;
	logic [15:0] tex_u_s1, tex_v_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			m_sx_s1 <= item.shift_x * chop_q;
			m_sy_s1 <= item.shift_y * chop_q;
			m_hz_s1 <= item.raw_height * gain_q;
			m_slx_s1 <= item.raw_slope_x * gain_q;
			m_sly_s1 <= item.raw_slope_y * gain_q;
			m_xx_s1 <= item.dsx_by_x * chop_q;
			m_xy_s1 <= item.dsx_by_y * chop_q;
			m_yx_s1 <= item.dsy_by_x * chop_q;
			m_yy_s1 <= item.dsy_by_y * chop_q;
			r_x_s1 <= $signed({1'b0, ext_x_q}) * offs_x;
			r_y_s1 <= $signed({1'b0, ext_y_q}) * offs_y;
			tex_u_s1 <= 16'(32'(colm) << (16 - GRID_X_LOG2));
			tex_v_s1 <= 16'(32'(rowm) << (16 - GRID_Y_LOG2));
		end
	end

	// Stage 2: rounding, positions and tangent terms.
	logic signed [RX_W-1:0] rest_x;
	logic signed [RY_W-1:0] rest_y;
	logic signed [19:0] hx_c, hy_c;
	pass_t pass_c2;

	assign rest_x = r_x_s1 >>> GRID_X_LOG2;
	assign rest_y = r_y_s1 >>> GRID_Y_LOG2;
	assign hx_c = rnd12(m_slx_s1);
	assign hy_c = rnd12(m_sly_s1);

	always_comb begin
		pass_c2.pos_x = sat24(40'(rest_x) + 40'(rnd12(m_sx_s1)));
		pass_c2.pos_y = sat24(40'(rest_y) + 40'(rnd12(m_sy_s1)));
		pass_c2.pos_z = sat24(40'(rnd12(m_hz_s1)));
		pass_c2.tex_u = tex_u_s1;
		pass_c2.tex_v = tex_v_s1;
		pass_c2.slope_x = 24'(hx_c);
		pass_c2.slope_y = 24'(hy_c);
		pass_c2.sgn = '0;
		pass_c2.zero = 1'b0;
	end

	pass_t pass_s2;
	logic signed [19:0] hx_s2, hy_s2, b_s2, c_s2;
	logic signed [20:0] tx0_s2, ty1_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			pass_s2 <= pass_c2;
			hx_s2 <= hx_c;
			hy_s2 <= hy_c;
			b_s2 <= rnd12(m_yx_s1);
			c_s2 <= rnd12(m_xy_s1);
			tx0_s2 <= 21'(rnd12(m_xx_s1)) + 21'sd4096;
			ty1_s2 <= 21'(rnd12(m_yy_s1)) + 21'sd4096;
		end
	end

	// Stage 3: cross product terms.
	pass_t pass_s3;
	logic signed [41:0] p_bhy_s3, p_hxty_s3, p_hxc_s3, p_txhy_s3, p_txty_s3, p_bc_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			pass_s3 <= pass_s2;
			p_bhy_s3 <= b_s2 * hy_s2;
			p_hxty_s3 <= hx_s2 * ty1_s2;
			p_hxc_s3 <= hx_s2 * c_s2;
			p_txhy_s3 <= tx0_s2 * hy_s2;
			p_txty_s3 <= tx0_s2 * ty1_s2;
			p_bc_s3 <= b_s2 * c_s2;
		end
	end

	// Stage 4: cross product, signs and magnitudes.
	logic signed [41:0] n_c [3];
	pass_t pass_c4;
	logic [2:0][41:0] mag_c4;

	always_comb begin
		n_c[0] = p_bhy_s3 - p_hxty_s3;
		n_c[1] = p_hxc_s3 - p_txhy_s3;
		n_c[2] = p_txty_s3 - p_bc_s3;
		pass_c4 = pass_s3;
		for (int i = 0; i < 3; i++) begin
			pass_c4.sgn[i] = n_c[i][41];
			mag_c4[i] = n_c[i][41] ? 42'(-n_c[i]) : 42'(n_c[i]);
		end
	end

	pass_t pass_s4;
	logic [2:0][41:0] mag_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			pass_s4 <= pass_c4;
			mag_s4 <= mag_c4;
		end
	end

	// Stage 5: leading one of the largest magnitude.
	logic [41:0] mag_or;
	logic [5:0]  msb_c;
	pass_t pass_c5;

	assign mag_or = mag_s4[0] | mag_s4[1] | mag_s4[2];

	always_comb begin
		msb_c = '0;
		for (int i = 0; i < 42; i++)
			if (mag_or[i])
				msb_c = 6'(i);
		pass_c5 = pass_s4;
		pass_c5.zero = (mag_or == '0);
	end

	pass_t pass_s5;
	logic [2:0][41:0] mag_s5;
	logic [5:0] msb_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			pass_s5 <= pass_c5;
			mag_s5 <= mag_s4;
			msb_s5 <= msb_c;
		end
	end

	// Stage 6: common shift so that the largest magnitude sits in [2^29, 2^30).
	logic [2:0][MAG_W-1:0] nrm_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (msb_s5 < 6'd29)
				nrm_c[i] = MAG_W'(mag_s5[i] << (6'd29 - msb_s5));
			else
				nrm_c[i] = MAG_W'(mag_s5[i] >> (msb_s5 - 6'd29));
		end
	end

	pass_t pass_s6;
	logic [2:0][MAG_W-1:0] nrm_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			pass_s6 <= pass_s5;
			nrm_s6 <= nrm_c;
		end
	end

	// Stage 7: squares.
	pass_t pass_s7;
	logic [2:0][MAG_W-1:0] nrm_s7;
	logic [2:0][2*MAG_W-1:0] sqr_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			pass_s7 <= pass_s6;
			nrm_s7 <= nrm_s6;
			for (int i = 0; i < 3; i++)
				sqr_s7[i] <= nrm_s6[i] * nrm_s6[i];
		end
	end

	// Stage 8: sum of squares.
	pass_t pass_s8;
	logic [2:0][MAG_W-1:0] nrm_s8;
	logic [2*MAG_W+1:0] sum_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			pass_s8 <= pass_s7;
			nrm_s8 <= nrm_s7;
			sum_s8 <= (2*MAG_W+2)'(sqr_s7[0]) + (2*MAG_W+2)'(sqr_s7[1])
				+ (2*MAG_W+2)'(sqr_s7[2]);
		end
	end

	// Square root pipeline, two root bits per stage.
	sq_t                   sq_st_s   [SQ_STAGES];
	logic [RAD_W-1:0]      sq_rad_s  [SQ_STAGES];
	pass_t                 sq_pass_s [SQ_STAGES];
	logic [2:0][MAG_W-1:0] sq_nrm_s  [SQ_STAGES];

	for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sq
		sq_t                   cur;
		sq_t                   nxt;
		logic [RAD_W-1:0]      rad;
		pass_t                 pin;
		logic [2:0][MAG_W-1:0] nin;

		if (g == 0) begin : g_first
			assign cur = '0;
			assign rad = RAD_W'(sum_s8);
			assign pin = pass_s8;
			assign nin = nrm_s8;
		end else begin : g_next
			assign cur = sq_st_s[g-1];
			assign rad = sq_rad_s[g-1];
			assign pin = sq_pass_s[g-1];
			assign nin = sq_nrm_s[g-1];
		end

		always_comb begin
			nxt = cur;
			for (int k = 0; k < SQ_PER_ST; k++)
				nxt = sqrt_step(nxt, rad[RAD_W-1-2*k -: 2]);
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_st_s[g] <= nxt;
				sq_rad_s[g] <= rad << (2 * SQ_PER_ST);
				sq_pass_s[g] <= pin;
				sq_nrm_s[g] <= nin;
			end
		end
	end

	// Divider pipeline: three lanes share the length, two quotient bits per stage.
	dv_t [2:0]         dv_st_s   [DV_STAGES];
	logic [2:0][15:0]  dv_low_s  [DV_STAGES];
	logic [30:0]       dv_len_s  [DV_STAGES];
	pass_t             dv_pass_s [DV_STAGES];

	for (genvar g = 0; g < DV_STAGES; g++) begin : g_dv
		dv_t [2:0]        cur;
		dv_t [2:0]        nxt;
		logic [2:0][15:0] low;
		logic [30:0]      len;
		pass_t            pin;
		logic [44:0]      num [3];

		if (g == 0) begin : g_first
			always_comb begin
				len = sq_st_s[SQ_STAGES-1].root[30:0];
				pin = sq_pass_s[SQ_STAGES-1];
				for (int l = 0; l < 3; l++) begin
					num[l] = {1'b0, sq_nrm_s[SQ_STAGES-1][l], 14'd0} + 45'(len >> 1);
					cur[l].rem = 31'(num[l][44:16]);
					cur[l].quo = '0;
					low[l] = num[l][15:0];
				end
			end
		end else begin : g_next
			always_comb begin
				len = dv_len_s[g-1];
				pin = dv_pass_s[g-1];
				cur = dv_st_s[g-1];
				low = dv_low_s[g-1];
				for (int l = 0; l < 3; l++)
					num[l] = '0;
			end
		end

		always_comb begin
			nxt = cur;
			for (int l = 0; l < 3; l++)
				for (int k = 0; k < DV_PER_ST; k++)
					nxt[l] = div_step(nxt[l], low[l][15-k], len);
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_st_s[g] <= nxt;
				for (int l = 0; l < 3; l++)
					dv_low_s[g][l] <= low[l] << DV_PER_ST;
				dv_len_s[g] <= len;
				dv_pass_s[g] <= pin;
			end
		end
	end

	// Output stage: clamp, restore signs, substitute the flat normal.
	pass_t pass_o;
	logic signed [15:0] nrm_o [3];
	logic [2:0][QUO_W-1:0] q_c;

	always_comb begin
		for (int l = 0; l < 3; l++)
			q_c[l] = (dv_st_s[DV_STAGES-1][l].quo > UNIT_Q14) ? UNIT_Q14
				: dv_st_s[DV_STAGES-1][l].quo;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pass_o <= dv_pass_s[DV_STAGES-1];
			for (int l = 0; l < 3; l++) begin
				if (dv_pass_s[DV_STAGES-1].zero)
					nrm_o[l] <= (l == 2) ? $signed(UNIT_Q14) : 16'sd0;
				else if (dv_pass_s[DV_STAGES-1].sgn[l])
					nrm_o[l] <= -$signed(q_c[l]);
				else
					nrm_o[l] <= $signed(q_c[l]);
			end
		end
	end

	assign result.valid = vld_q[NUM_STAGES-1];
	assign result.pos_x = pass_o.pos_x;
	assign result.pos_y = pass_o.pos_y;
	assign result.pos_z = pass_o.pos_z;
	assign result.norm_x = nrm_o[0];
	assign result.norm_y = nrm_o[1];
	assign result.norm_z = nrm_o[2];
	assign result.tex_u = pass_o.tex_u;
	assign result.tex_v = pass_o.tex_v;
	assign result.out_slope_x = pass_o.slope_x;
	assign result.out_slope_y = pass_o.slope_y;

	// A waiting result blocks new transactions.
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |-> !item.ready)
		else $error("item accepted while result stalled");

	// A stalled pipeline keeps its occupancy.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipeline occupancy changed during stall");

	// An accepted transaction enters the first stage.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> vld_q[0])
		else $error("accepted item lost at pipeline entry");

	// The x and z normal components never exceed one in magnitude.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.norm_x <= 16'sd16384 && result.norm_x >= -16'sd16384
			&& result.norm_z <= 16'sd16384 && result.norm_z >= -16'sd16384))
		else $error("normal component out of range");

endmodule
